/* src/accel_tilt_pitch_roll_top_assert.svh */
// Assertion macros shared by the checker of the tilt block.
`ifndef ACCEL_TILT_PITCH_ROLL_TOP_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define ATPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form built on the macro above.
`define ATPR_ASSERT_IMP(lbl, ante, cons, msg) \
  `ATPR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* src/atpr_pkg.sv */
// Types, constants and the arctangent table of the tilt block.
package atpr_pkg;

  localparam int PITCH_W  = 15;
  localparam int ROLL_W   = 16;
  localparam int ZW       = 27;
  localparam int FRAC     = 16;
  localparam int ATAN_LEN = 24;
  localparam int RND_SH   = 9;

  localparam logic signed [ZW-1:0] DEG90     = 27'sd5898240;
  localparam logic signed [ZW-1:0] DEG180    = 27'sd11796480;
  localparam logic signed [ZW-1:0] RND_HALF  = 27'sd256;
  localparam logic signed [ZW-1:0] PITCH_LIM = 27'sd11520;
  localparam logic signed [ZW-1:0] ROLL_LIM  = 27'sd23040;

  typedef struct packed {
    logic valid;
    logic p_y0;
    logic p_x0;
    logic p_yneg;
    logic r_y0;
    logic r_x0;
    logic r_yneg;
    logic r_flip;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 27'sd2949120;
      1:  a = 27'sd1740967;
      2:  a = 27'sd919879;
      3:  a = 27'sd466945;
      4:  a = 27'sd234379;
      5:  a = 27'sd117304;
      6:  a = 27'sd58666;
      7:  a = 27'sd29335;
      8:  a = 27'sd14668;
      9:  a = 27'sd7334;
      10: a = 27'sd3667;
      11: a = 27'sd1833;
      12: a = 27'sd917;
      13: a = 27'sd458;
      14: a = 27'sd229;
      15: a = 27'sd115;
      16: a = 27'sd57;
      17: a = 27'sd29;
      18: a = 27'sd14;
      19: a = 27'sd7;
      20: a = 27'sd4;
      21: a = 27'sd2;
      22: a = 27'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [ZW-1:0] round_sat(input logic signed [ZW-1:0] z,
                                                      input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] s;
    s = (z + RND_HALF) >>> RND_SH;
    if (s > lim) begin
      s = lim;
    end else if (s < -lim) begin
      s = -lim;
    end
    return s;
  endfunction

endpackage

/* src/atpr_if.sv */
// Request channels of the tilt block: accelerometer samples in, angles out.
interface atpr_in_if #(parameter int SAMPLE_BITS = 12);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atpr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [atpr_pkg::PITCH_W-1:0] pitch_angle;
  logic signed [atpr_pkg::ROLL_W-1:0]  roll_angle;
  modport source (output valid, pitch_angle, roll_angle, input ready);
  modport sink (input valid, pitch_angle, roll_angle, output ready);
endinterface

/* src/atpr_sqrt_cell.sv */
// One root bit of the restoring square root, registered.
module atpr_sqrt_cell #(
  parameter int RW = 28,
  parameter int PW = 36
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  atpr_pkg::ctl_t     ctl_i,
  input  logic [RW+1:0]      rem_i,
  input  logic [RW-1:0]      root_i,
  input  logic [2*RW-1:0]    vs_i,
  input  logic [PW-1:0]      pass_i,
  output atpr_pkg::ctl_t     ctl_o,
  output logic [RW+1:0]      rem_o,
  output logic [RW-1:0]      root_o,
  output logic [2*RW-1:0]    vs_o,
  output logic [PW-1:0]      pass_o
);

  logic [RW+3:0]   cur;
  logic [RW+3:0]   trial;
  logic [RW+1:0]   rem_d;
  logic [RW-1:0]   root_d;

  always_comb begin
    cur   = {rem_i, vs_i[2*RW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    if (cur >= trial) begin
      rem_d  = (RW+2)'(cur - trial);
      root_d = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_d  = cur[RW+1:0];
      root_d = {root_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      vs_o   <= {vs_i[2*RW-3:0], 2'b00};
      pass_o <= pass_i;
    end
  end

endmodule

/* src/atpr_cordic_cell.sv */
// One vectoring micro-rotation for the pitch and the roll vector, registered.
module atpr_cordic_cell #(
  parameter int W     = 31,
  parameter int STAGE = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  atpr_pkg::ctl_t                      ctl_i,
  input  logic signed [W-1:0]                 px_i,
  input  logic signed [W-1:0]                 py_i,
  input  logic signed [atpr_pkg::ZW-1:0]      pz_i,
  input  logic signed [W-1:0]                 rx_i,
  input  logic signed [W-1:0]                 ry_i,
  input  logic signed [atpr_pkg::ZW-1:0]      rz_i,
  output atpr_pkg::ctl_t                      ctl_o,
  output logic signed [W-1:0]                 px_o,
  output logic signed [W-1:0]                 py_o,
  output logic signed [atpr_pkg::ZW-1:0]      pz_o,
  output logic signed [W-1:0]                 rx_o,
  output logic signed [W-1:0]                 ry_o,
  output logic signed [atpr_pkg::ZW-1:0]      rz_o
);

  localparam bit ACTIVE = (STAGE < atpr_pkg::ATAN_LEN);

  logic signed [atpr_pkg::ZW-1:0] ang;
  logic signed [W-1:0]            pxs, pys, rxs, rys;
  logic signed [W-1:0]            px_d, py_d, rx_d, ry_d;
  logic signed [atpr_pkg::ZW-1:0] pz_d, rz_d;

  always_comb begin
    ang  = atpr_pkg::atan_deg(STAGE);
    pxs  = px_i >>> STAGE;
    pys  = py_i >>> STAGE;
    rxs  = rx_i >>> STAGE;
    rys  = ry_i >>> STAGE;
    px_d = px_i;
    py_d = py_i;
    pz_d = pz_i;
    rx_d = rx_i;
    ry_d = ry_i;
    rz_d = rz_i;
    if (ACTIVE) begin
      if (!py_i[W-1]) begin
        px_d = px_i + pys;
        py_d = py_i - pxs;
        pz_d = pz_i + ang;
      end else begin
        px_d = px_i - pys;
        py_d = py_i + pxs;
        pz_d = pz_i - ang;
      end
      if (!ry_i[W-1]) begin
        rx_d = rx_i + rys;
        ry_d = ry_i - rxs;
        rz_d = rz_i + ang;
      end else begin
        rx_d = rx_i - rys;
        ry_d = ry_i + rxs;
        rz_d = rz_i - ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_o <= px_d;
      py_o <= py_d;
      pz_o <= pz_d;
      rx_o <= rx_d;
      ry_o <= ry_d;
      rz_o <= rz_d;
    end
  end

endmodule

/* src/accel_tilt_pitch_roll_top.sv */
// Tilt from one accelerometer sample: pitch and roll in degrees with 7 fraction bits.
// A new sample is taken every cycle while results are drained. A sample's
// angles pass through these steps in order: a register forms Y^2 + Z^2,
// a row of SAMPLE_BITS + 16 square-root cells settles one root bit each,
// a row of CORDIC_STAGES cells rotates the pitch and roll vectors side
// by side, and a final register rounds, saturates and holds the result.
// The whole row stalls only while a finished result waits and is not taken.
module accel_tilt_pitch_roll_top #(
  parameter int SAMPLE_BITS   = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atpr_in_if.sink     sample_i,
  atpr_out_if.source  angle_o
);

  localparam int S   = SAMPLE_BITS;
  localparam int RW  = S + atpr_pkg::FRAC;
  localparam int SQW = 2 * S;
  localparam int W   = S + 19;
  localparam int PW  = 3 * S;
  localparam int C   = CORDIC_STAGES;

  logic en;
  logic out_valid_q;
  logic signed [atpr_pkg::PITCH_W-1:0] pitch_q;
  logic signed [atpr_pkg::ROLL_W-1:0]  roll_q;

  logic signed [S-1:0]   ax, ay, az;
  logic signed [SQW-1:0] ysq, zsq;
  atpr_pkg::ctl_t        ctl0_d, ctl0_q;
  logic [SQW-1:0]        sq0_q;
  logic [PW-1:0]         pass0_q;

  atpr_pkg::ctl_t        sctl  [RW+1];
  logic [RW+1:0]         srem  [RW+1];
  logic [RW-1:0]         sroot [RW+1];
  logic [2*RW-1:0]       svs   [RW+1];
  logic [PW-1:0]         spass [RW+1];

  atpr_pkg::ctl_t                 cctl [C+1];
  logic signed [W-1:0]            cpx  [C+1];
  logic signed [W-1:0]            cpy  [C+1];
  logic signed [atpr_pkg::ZW-1:0] cpz  [C+1];
  logic signed [W-1:0]            crx  [C+1];
  logic signed [W-1:0]            cry  [C+1];
  logic signed [atpr_pkg::ZW-1:0] crz  [C+1];

  logic signed [S-1:0]            eax, eay, eaz;
  logic signed [S:0]              nay, naz;
  atpr_pkg::ctl_t                 fctl;
  logic signed [atpr_pkg::ZW-1:0] pz_f, rz_f, pa, ra;

  assign en             = !out_valid_q || angle_o.ready;
  assign sample_i.ready = en;

  assign ax = sample_i.accel_x;
  assign ay = sample_i.accel_y;
  assign az = sample_i.accel_z;
  assign ysq = ay * ay;
  assign zsq = az * az;

  always_comb begin
    ctl0_d.valid  = sample_i.valid;
    ctl0_d.p_y0   = (ax == '0);
    ctl0_d.p_x0   = (ay == '0) && (az == '0);
    ctl0_d.p_yneg = ax[S-1];
    ctl0_d.r_y0   = (ay == '0);
    ctl0_d.r_x0   = (az == '0);
    ctl0_d.r_yneg = ay[S-1];
    ctl0_d.r_flip = az[S-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (en) begin
      ctl0_q <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq0_q   <= SQW'(ysq) + SQW'(zsq);
      pass0_q <= {ax, ay, az};
    end
  end

  assign sctl[0]  = ctl0_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign svs[0]   = {sq0_q, {(2 * atpr_pkg::FRAC){1'b0}}};
  assign spass[0] = pass0_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    atpr_sqrt_cell #(.RW(RW), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sctl[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .vs_i   (svs[k]),
      .pass_i (spass[k]),
      .ctl_o  (sctl[k+1]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1]),
      .vs_o   (svs[k+1]),
      .pass_o (spass[k+1])
    );
  end

  assign eax = spass[RW][3*S-1 -: S];
  assign eay = spass[RW][2*S-1 -: S];
  assign eaz = spass[RW][S-1:0];
  assign nay = -{eay[S-1], eay};
  assign naz = -{eaz[S-1], eaz};

  assign cctl[0] = sctl[RW];
  assign cpx[0]  = W'(sroot[RW]);
  assign cpy[0]  = {{(W-S-16){eax[S-1]}}, eax, 16'b0};
  assign cpz[0]  = '0;
  assign crx[0]  = sctl[RW].r_flip ? {{(W-S-17){naz[S]}}, naz, 16'b0}
                                   : {{(W-S-16){eaz[S-1]}}, eaz, 16'b0};
  assign cry[0]  = sctl[RW].r_flip ? {{(W-S-17){nay[S]}}, nay, 16'b0}
                                   : {{(W-S-16){eay[S-1]}}, eay, 16'b0};
  assign crz[0]  = '0;

  for (genvar i = 0; i < C; i++) begin : g_cordic
    atpr_cordic_cell #(.W(W), .STAGE(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (cctl[i]),
      .px_i   (cpx[i]),
      .py_i   (cpy[i]),
      .pz_i   (cpz[i]),
      .rx_i   (crx[i]),
      .ry_i   (cry[i]),
      .rz_i   (crz[i]),
      .ctl_o  (cctl[i+1]),
      .px_o   (cpx[i+1]),
      .py_o   (cpy[i+1]),
      .pz_o   (cpz[i+1]),
      .rx_o   (crx[i+1]),
      .ry_o   (cry[i+1]),
      .rz_o   (crz[i+1])
    );
  end

  assign fctl = cctl[C];

  always_comb begin
    if (fctl.p_y0) begin
      pz_f = '0;
    end else if (fctl.p_x0) begin
      pz_f = fctl.p_yneg ? -atpr_pkg::DEG90 : atpr_pkg::DEG90;
    end else begin
      pz_f = cpz[C];
    end
    if (fctl.r_y0) begin
      rz_f = '0;
    end else if (fctl.r_x0) begin
      rz_f = fctl.r_yneg ? -atpr_pkg::DEG90 : atpr_pkg::DEG90;
    end else begin
      rz_f = crz[C];
    end
    if (fctl.r_flip) begin
      rz_f = fctl.r_yneg ? rz_f - atpr_pkg::DEG180 : rz_f + atpr_pkg::DEG180;
    end
    pa = atpr_pkg::round_sat(pz_f, atpr_pkg::PITCH_LIM);
    ra = atpr_pkg::round_sat(rz_f, atpr_pkg::ROLL_LIM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_q <= pa[atpr_pkg::PITCH_W-1:0];
      roll_q  <= ra[atpr_pkg::ROLL_W-1:0];
    end
  end

  assign angle_o.valid       = out_valid_q;
  assign angle_o.pitch_angle = pitch_q;
  assign angle_o.roll_angle  = roll_q;

endmodule

/* src/atpr_checker.sv */
// Port checker of the tilt block and its bind to the top level.
`include "accel_tilt_pitch_roll_top_assert.svh"

module atpr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [atpr_pkg::PITCH_W-1:0] pitch_i,
  input logic signed [atpr_pkg::ROLL_W-1:0]  roll_i
);

  logic signed [atpr_pkg::PITCH_W-1:0] pitch_lim;
  logic signed [atpr_pkg::ROLL_W-1:0]  roll_lim;

  assign pitch_lim = atpr_pkg::PITCH_LIM[atpr_pkg::PITCH_W-1:0];
  assign roll_lim  = atpr_pkg::ROLL_LIM[atpr_pkg::ROLL_W-1:0];

  `ATPR_ASSERT_IMP(a_pitch_range, out_valid_i, (pitch_i <= pitch_lim) && (pitch_i >= -pitch_lim), "pitch out of range")
  `ATPR_ASSERT_IMP(a_roll_range, out_valid_i, (roll_i <= roll_lim) && (roll_i >= -roll_lim), "roll out of range")
  `ATPR_ASSERT_IMP(a_ready_when_empty, !out_valid_i, in_ready_i, "input stalled with empty output")
  `ATPR_ASSERT_IMP(a_hold_result, out_valid_i && !out_ready_i, ##1 (out_valid_i && $stable(pitch_i) && $stable(roll_i)), "stalled result changed")

endmodule

bind accel_tilt_pitch_roll_top atpr_checker u_atpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (angle_o.valid),
  .out_ready_i (angle_o.ready),
  .pitch_i     (angle_o.pitch_angle),
  .roll_i      (angle_o.roll_angle)
);

/* tb/tb.sv */
// Testbench of the tilt block: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int PITCH_W  = atpr_pkg::PITCH_W;
  localparam int ROLL_W   = atpr_pkg::ROLL_W;
  localparam int N_RANDOM = 1530;
  localparam int N_DIR    = 16;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ROLL_W-1:0]  roll;
  } tilt_t;

  typedef struct packed {
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] az;
    logic               typed;
    tilt_t              want;
  } stim_t;

  localparam longint TURN90  = 90 * 65536;
  localparam longint TURN180 = 180 * 65536;
  localparam longint ARCTAN_DEG[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic clk;
  logic rst_n;
  atpr_in_if #(.SAMPLE_BITS(12)) smp ();
  atpr_out_if ang ();

  accel_tilt_pitch_roll_top #(.SAMPLE_BITS(12), .CORDIC_STAGES(16)) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(smp.sink),
    .angle_o (ang.source)
  );

  tilt_t angles_due[$];
  int    errors;
  int    send_idle_pct;
  int    recv_idle_pct;
  int    recv_hold;
  stim_t dir_rows[N_DIR];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (y == 0) return 0;
    if (x == 0) return (y > 0) ? TURN90 : -TURN90;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ARCTAN_DEG[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ARCTAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_clamp(longint z, longint lim);
    longint a;
    a = (z + 256) >>> 9;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic tilt_t tilt_of(logic signed [11:0] ax, logic signed [11:0] ay,
                                    logic signed [11:0] az);
    longint x;
    longint y;
    longint z;
    longint r;
    longint rz;
    tilt_t  t;
    x = ax;
    y = ay;
    z = az;
    r = longint'(int_root(longint'(y * y + z * z) << 32));
    if (z < 0) begin
      rz = cordic_angle(-z * 65536, -y * 65536);
      rz += (y >= 0) ? TURN180 : -TURN180;
    end else begin
      rz = cordic_angle(z * 65536, y * 65536);
    end
    t.pitch = PITCH_W'(round_clamp(cordic_angle(r, x * 65536), 11520));
    t.roll  = ROLL_W'(round_clamp(rz, 23040));
    return t;
  endfunction

  function automatic logic signed [11:0] rand_axis();
    case ($urandom_range(9))
      0: return 12'sd0;
      1: return -12'sd2048;
      2: return 12'sd2047;
      3: return 12'($signed($urandom_range(64)) - 32);
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic report(string what, tilt_t got, tilt_t want);
    errors++;
    $display("%0t mismatch %s: got pitch %0d roll %0d, want pitch %0d roll %0d",
             $time, what, got.pitch, got.roll, want.pitch, want.roll);
  endtask

  task automatic send(logic signed [11:0] ax, logic signed [11:0] ay,
                      logic signed [11:0] az, logic typed, tilt_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid = 1'b0;
      @(negedge clk);
    end
    smp.valid   = 1'b1;
    smp.accel_x = ax;
    smp.accel_y = ay;
    smp.accel_z = az;
    do @(posedge clk); while (!smp.ready);
    angles_due.push_back(typed ? want : tilt_of(ax, ay, az));
    @(negedge clk);
    smp.valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (recv_hold > 0) begin
      ang.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      ang.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    tilt_t got;
    tilt_t want;
    if (rst_n && ang.valid && ang.ready) begin
      got.pitch = ang.pitch_angle;
      got.roll  = ang.roll_angle;
      if (angles_due.size() == 0) begin
        report("unexpected request", got, got);
      end else begin
        want = angles_due.pop_front();
        if (got.pitch !== want.pitch) report("pitch", got, want);
        if (got.roll !== want.roll) report("roll", got, want);
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    smp.valid = 1'b0;
    smp.accel_x = '0;
    smp.accel_y = '0;
    smp.accel_z = '0;
    ang.ready = 1'b0;
    rst_n = 1'b0;
    dir_rows = '{
      '{12'sd0, 12'sd0, 12'sd0, 1'b1, '{15'sd0, 16'sd0}},
      '{12'sd0, 12'sd0, 12'sd1024, 1'b1, '{15'sd0, 16'sd0}},
      '{12'sd0, 12'sd0, -12'sd1024, 1'b1, '{15'sd0, 16'sd23040}},
      '{12'sd0, 12'sd1024, 12'sd0, 1'b1, '{15'sd0, 16'sd11520}},
      '{12'sd0, -12'sd1024, 12'sd0, 1'b1, '{15'sd0, -16'sd11520}},
      '{12'sd2047, 12'sd0, 12'sd0, 1'b1, '{15'sd11520, 16'sd0}},
      '{-12'sd2048, 12'sd0, 12'sd0, 1'b1, '{-15'sd11520, 16'sd0}},
      '{12'sd0, 12'sd0, -12'sd2048, 1'b1, '{15'sd0, 16'sd23040}},
      '{12'sd2047, 12'sd2047, 12'sd2047, 1'b0, '0},
      '{-12'sd2048, -12'sd2048, -12'sd2048, 1'b0, '0},
      '{12'sd1, -12'sd1, -12'sd2048, 1'b0, '0},
      '{-12'sd1, 12'sd1, -12'sd2048, 1'b0, '0},
      '{12'sd1024, 12'sd724, 12'sd724, 1'b0, '0},
      '{-12'sd1000, -12'sd2048, 12'sd1, 1'b0, '0},
      '{12'sd5, 12'sd2047, -12'sd1, 1'b0, '0},
      '{12'sd0, 12'sd1, 12'sd1, 1'b0, '0}};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az, dir_rows[i].typed,
           dir_rows[i].want);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 35 : 0;
      if (ph == 2) recv_hold = 300;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        send(rand_axis(), rand_axis(), rand_axis(), 1'b0, '0);
      end
      // hold until the block drains
      while (angles_due.size() != 0) @(negedge clk);
    end
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* accel_tilt_pitch_roll_top.f */
+incdir+src
src/atpr_pkg.sv
src/atpr_if.sv
src/atpr_sqrt_cell.sv
src/atpr_cordic_cell.sv
src/accel_tilt_pitch_roll_top.sv
src/atpr_checker.sv
tb/tb.sv
